// ===== src/malu_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package malu_pkg;
  localparam logic [5:0] OP_RTYPE = 6'd0;
  localparam logic [5:0] OP_ADDI  = 6'd8;
  localparam logic [5:0] OP_ADDIU = 6'd9;
  localparam logic [5:0] OP_SLTI  = 6'd10;
  localparam logic [5:0] OP_SLTIU = 6'd11;

  localparam logic [5:0] FN_SLL  = 6'd0;
  localparam logic [5:0] FN_SRL  = 6'd2;
  localparam logic [5:0] FN_SRA  = 6'd3;
  localparam logic [5:0] FN_SLLV = 6'd4;
  localparam logic [5:0] FN_SRLV = 6'd6;
  localparam logic [5:0] FN_MULT = 6'd24;
  localparam logic [5:0] FN_MULTU = 6'd25;
  localparam logic [5:0] FN_DIV  = 6'd26;
  localparam logic [5:0] FN_DIVU = 6'd27;
  localparam logic [5:0] FN_ADD  = 6'd32;
  localparam logic [5:0] FN_ADDU = 6'd33;
  localparam logic [5:0] FN_SUB  = 6'd34;
  localparam logic [5:0] FN_SUBU = 6'd35;
  localparam logic [5:0] FN_AND  = 6'd36;
  localparam logic [5:0] FN_OR   = 6'd37;
  localparam logic [5:0] FN_XOR  = 6'd38;
  localparam logic [5:0] FN_SLT  = 6'd42;
  localparam logic [5:0] FN_SLTU = 6'd43;

  localparam logic [4:0] REG_REM = 5'd30;
  localparam logic [4:0] REG_QUO = 5'd31;

  typedef enum logic [2:0] {
    ST_IDLE, ST_READ, ST_EXEC, ST_DIV, ST_OUT0, ST_OUT1
  } state_t;

  typedef struct packed {
    logic load;     // capture item
    logic exec;     // compute single op / start divide
    logic div_step; // one quotient bit
    logic div_fin;  // sign fixup
    logic wr0;      // result 0 delivered
    logic wr1;      // result 1 delivered
  } cmd_t;

  typedef struct packed {
    logic is_div;
    logic div_done;
  } sts_t;
endpackage
`default_nettype wire

// ===== src/malu_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module malu_ctrl (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  wire logic         out_ready,
  output malu_pkg::cmd_t    cmd,
  input  wire malu_pkg::sts_t sts
);
  malu_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= malu_pkg::ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    unique case (state)
      malu_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = malu_pkg::ST_READ;
        end
      end
      malu_pkg::ST_READ: state_next = malu_pkg::ST_EXEC;
      malu_pkg::ST_EXEC: begin
        cmd.exec = 1'b1;
        state_next = sts.is_div ? malu_pkg::ST_DIV : malu_pkg::ST_OUT1;
      end
      malu_pkg::ST_DIV: begin
        if (sts.div_done) begin
          cmd.div_fin = 1'b1;
          state_next = malu_pkg::ST_OUT0;
        end else cmd.div_step = 1'b1;
      end
      malu_pkg::ST_OUT0: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cmd.wr0 = 1'b1;
          state_next = malu_pkg::ST_OUT1;
        end
      end
      malu_pkg::ST_OUT1: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cmd.wr1 = 1'b1;
          state_next = malu_pkg::ST_IDLE;
        end
      end
      default: state_next = malu_pkg::ST_IDLE;
    endcase
  end

  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> state == malu_pkg::ST_READ) else $error("load");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("out hold");
  a_no_in_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("in_ready busy");
endmodule
`default_nettype wire

// ===== src/malu_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
module malu_datapath (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire malu_pkg::cmd_t cmd,
  output malu_pkg::sts_t    sts,
  input  wire logic [5:0]   opcode,
  input  wire logic [4:0]   rs_index,
  input  wire logic [4:0]   rt_index,
  input  wire logic [4:0]   rd_index,
  input  wire logic [4:0]   shift_amount,
  input  wire logic [5:0]   func_code,
  input  wire logic [15:0]  immediate,
  output logic [4:0]        write_index,
  output logic [31:0]       write_value,
  output logic              div_by_zero,
  output logic              last
);
  logic [31:0] regs [32];
  logic [31:0] rvalid;
  logic [5:0]  op, fn;
  logic [4:0]  rt, rd, sa, rsi, rti;
  logic [15:0] imm;
  logic [31:0] a, b, ra, rb;
  logic [31:0] res, res_next;
  logic [4:0]  widx, widx_next;
  logic [31:0] quo, rem, dvs;
  logic [5:0]  cnt;
  logic        dz, neg_q, neg_r, is_div;
  logic [31:0] simm, ma, mb;
  logic [32:0] trial;
  logic        out_sel;

  assign simm = {{16{imm[15]}}, imm};
  assign is_div = (op == malu_pkg::OP_RTYPE) &&
                  (fn == malu_pkg::FN_DIV || fn == malu_pkg::FN_DIVU);
  assign sts.is_div = is_div;
  assign sts.div_done = (cnt == 6'd32);
  assign a = rvalid[rsi] ? ra : 32'd0;
  assign b = rvalid[rti] ? rb : 32'd0;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op <= opcode; rsi <= rs_index; rt <= rt_index;
      rd <= rd_index; sa <= shift_amount; fn <= func_code; imm <= immediate;
      rti <= rt_index;
    end
    ra <= regs[rsi];
    rb <= regs[rti];
  end

  always_ff @(posedge clk) begin
    if (rst) rvalid <= '0;
    else if ((cmd.wr0 || cmd.wr1) && write_index != 5'd0) begin
      rvalid[write_index] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if ((cmd.wr0 || cmd.wr1) && write_index != 5'd0) regs[write_index] <= write_value;
  end

  assign ma = (fn == malu_pkg::FN_DIV && a[31]) ? 32'd0 - a : a;
  assign mb = (fn == malu_pkg::FN_DIV && b[31]) ? 32'd0 - b : b;

  always_comb begin
    res_next = 32'd0;
    widx_next = rd;
    unique case (op)
      malu_pkg::OP_ADDI, malu_pkg::OP_ADDIU: begin
        res_next = a + simm; widx_next = rt;
      end
      malu_pkg::OP_SLTI: begin
        res_next = {31'd0, $signed(a) < $signed(simm)}; widx_next = rt;
      end
      malu_pkg::OP_SLTIU: begin
        res_next = {31'd0, a < simm}; widx_next = rt;
      end
      malu_pkg::OP_RTYPE: begin
        unique case (fn)
          malu_pkg::FN_SLL:  res_next = b << sa;
          malu_pkg::FN_SRL:  res_next = b >> sa;
          malu_pkg::FN_SRA:  res_next = 32'($signed(b) >>> sa);
          malu_pkg::FN_SLLV: res_next = b << a[4:0];
          malu_pkg::FN_SRLV: res_next = b >> a[4:0];
          malu_pkg::FN_MULT, malu_pkg::FN_MULTU: res_next = 32'(a * b);
          malu_pkg::FN_ADD, malu_pkg::FN_ADDU: res_next = a + b;
          malu_pkg::FN_SUB, malu_pkg::FN_SUBU: res_next = a - b;
          malu_pkg::FN_AND: res_next = a & b;
          malu_pkg::FN_OR:  res_next = a | b;
          malu_pkg::FN_XOR: res_next = a ^ b;
          malu_pkg::FN_SLT: res_next = {31'd0, $signed(a) < $signed(b)};
          malu_pkg::FN_SLTU: res_next = {31'd0, a < b};
          default: res_next = 32'd0;
        endcase
      end
      default: res_next = 32'd0;
    endcase
  end

  assign trial = {rem, quo[31]} - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res <= res_next;
      widx <= widx_next;
      quo <= ma;
      rem <= 32'd0;
      dvs <= mb;
      cnt <= 6'd0;
      dz <= (b == 32'd0) && is_div;
      neg_q <= (fn == malu_pkg::FN_DIV) && (a[31] ^ b[31]);
      neg_r <= (fn == malu_pkg::FN_DIV) && a[31];
      if (b == 32'd0 && is_div) begin
        quo <= 32'hFFFF_FFFF;
        rem <= a;
        cnt <= 6'd32;
      end
    end else if (cmd.div_step) begin
      cnt <= cnt + 6'd1;
      if (!trial[32]) begin
        rem <= trial[31:0];
        quo <= {quo[30:0], 1'b1};
      end else begin
        rem <= {rem[30:0], quo[31]};
        quo <= {quo[30:0], 1'b0};
      end
    end else if (cmd.div_fin && !dz) begin
      if (neg_q) quo <= 32'd0 - quo;
      if (neg_r) rem <= 32'd0 - rem;
    end
  end

  always_comb begin
    if (is_div) begin
      last = out_sel;
      write_index = out_sel ? malu_pkg::REG_QUO : malu_pkg::REG_REM;
      write_value = out_sel ? quo : rem;
      div_by_zero = dz;
    end else begin
      last = 1'b1;
      write_index = widx;
      write_value = res;
      div_by_zero = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_sel <= 1'b0;
    else if (cmd.exec) out_sel <= 1'b0;
    else if (cmd.wr0) out_sel <= 1'b1;
  end

  a_div_cnt: assert property (@(posedge clk) disable iff (rst)
    cmd.div_step |=> cnt == $past(cnt) + 6'd1) else $error("div count");
  a_r0: assert property (@(posedge clk) disable iff (rst)
    !rvalid[0]) else $error("r0 written");
  a_wr1_sel: assert property (@(posedge clk) disable iff (rst)
    cmd.wr1 && is_div |-> out_sel) else $error("order");
endmodule
`default_nettype wire

// ===== src/mips_alu_execute_stage.sv =====
// Channel | Handshake           | Payload
// in      | in_valid/in_ready   | opcode rs_index rt_index rd_index shift_amount func_code immediate
// out     | out_valid/out_ready | write_index write_value div_by_zero last
// Single-write items: the result is offered after accept once the read and execute states are done.
// Divide: results are offered after the read, execute, divide and sign-fixup steps; the
// restoring divider produces one quotient bit per cycle; a zero divisor skips the bit steps.
// One item in flight; in_ready is high only in idle, the cycle after the last result is taken.
// Reset clears control and register-file valid bits; unwritten registers read 0.
// out stalls hold the result; the next item waits until all results are taken.
`timescale 1ns / 1ps
`default_nettype none
module mips_alu_execute_stage (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [5:0]  opcode,
  input  wire logic [4:0]  rs_index,
  input  wire logic [4:0]  rt_index,
  input  wire logic [4:0]  rd_index,
  input  wire logic [4:0]  shift_amount,
  input  wire logic [5:0]  func_code,
  input  wire logic [15:0] immediate,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [4:0]       write_index,
  output logic [31:0]      write_value,
  output logic             div_by_zero,
  output logic             last
);
  malu_pkg::cmd_t cmd;
  malu_pkg::sts_t sts;

  malu_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .cmd, .sts
  );

  malu_datapath u_dp (
    .clk, .rst, .cmd, .sts, .opcode, .rs_index, .rt_index, .rd_index,
    .shift_amount, .func_code, .immediate, .write_index, .write_value,
    .div_by_zero, .last
  );
endmodule
`default_nettype wire
